### rtl/ngb_pkg.sv
// Package for the navigation grid builder: field widths, codes, reset values
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ngb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_RULE_COUNT = 4;
    localparam int DEF_MIN_COST   = 1;
    localparam int DEF_MAX_COST   = 255;
    localparam int DEF_SOLID_MASK = 1;

    localparam int RULE_SLOTS = 4;
    localparam int GW         = 9;      // grid size register / cell coordinate
    localparam int CSW        = 16;
    localparam int ICW        = 24;
    localparam int RW         = 24;     // rule register
    localparam int QW         = 24;     // Q15.8 rectangle fields
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 24;

    localparam logic [GW-1:0]  RST_GRID = 9'd256;
    localparam logic [CSW-1:0] RST_CS   = 16'd256;
    localparam logic [ICW-1:0] RST_ICS  = 24'd65536;

    localparam logic [16:0] CNT17_MAX = 17'h10000;
    localparam logic [15:0] CNT16_MAX = 16'hFFFF;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_TILE  = 2'd1;
    localparam logic [1:0] REQ_RECT  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_RECT = 2'd1;
    localparam logic [1:0] ST_OUT_MAP  = 2'd2;
    localparam logic [1:0] ST_BAD_RULE = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CELL_SIZE   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_INV_CELL    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RULE_0      = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_RULE_1      = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_RULE_2      = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_RULE_3      = 3'd7;

    typedef struct packed {
        logic load;
        logic dispatch;
        logic clr_start;
        logic clr_step;
        logic rd_cell;
        logic read_cap;
        logic tile_wr;
        logic rect_a;
        logic rect_b;
        logic mul_step;
        logic walk_init;
        logic walk_rd;
        logic walk_wr;
        logic out_load;
    } ngb_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       err;
        logic       tile_empty;
        logic       rect_skip;
        logic       mul_last;
        logic       walk_empty;
        logic       walk_last;
        logic       sweep_last;
        logic       out_busy;
    } ngb_sts_t;

endpackage
`default_nettype wire

### rtl/nav_grid_builder_top.sv
// Navigation grid builder, top level. Read and tile items: read, then capture or
// write; rejected or empty items go straight to the result; clear sweeps all
// MAX_WIDTH*MAX_HEIGHT cells; a rectangle computes its bounds, then reads and
// writes each covered cell (one read and one write port). One item in flight;
// the next word is taken while a result waits on m_. Reset is synchronous; a
// clearing pass follows with s_tready low. Depends on ngb_pkg, ngb_ctrl, ngb_dp.
`timescale 1ns / 1ps
`default_nettype none
module nav_grid_builder_top import ngb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int RULE_COUNT = DEF_RULE_COUNT,
    parameter int MIN_COST   = DEF_MIN_COST,
    parameter int MAX_COST   = DEF_MAX_COST,
    parameter int SOLID_MASK = DEF_SOLID_MASK
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_wr_index,
    input  wire logic [CFG_DW-1:0] cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // cell_x, cell_y, tile_empty, material_flags, rect_x, rect_y, rect_width,
    // rect_height
    input  wire logic [135:0]      s_tdata,
    input  wire logic [1:0]        s_tuser,    // req_type
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // out_blocked, out_cost, solid_count, weighted_count, peak_cost, rect_count,
    // blocked_count
    output logic [87:0]            m_tdata,
    output logic [1:0]             m_tuser     // status
);
    ngb_cmd_t cmd;
    ngb_sts_t sts;

    ngb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ngb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RULE_COUNT (RULE_COUNT),
        .MIN_COST   (MIN_COST),
        .MAX_COST   (MAX_COST),
        .SOLID_MASK (SOLID_MASK)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cmd          (cmd),
        .sts          (sts)
    );

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while item in flight");

    // cell fields are zero unless the status is ok
    a_err_no_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[8:0] == 9'd0))
        else $error("cell fields set on an error result");

    // a peak cost implies at least one weighted tile
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[50:43] != 8'd0) |-> (m_tdata[42:26] != 17'd0))
        else $error("peak cost without weighted tiles");
endmodule
`default_nettype wire

### rtl/ngb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ngb_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/ngb_ctrl.sv
// Sequencer of the grid builder: walks each word through its steps and
// drives the datapath commands. Depends on ngb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ngb_ctrl import ngb_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire ngb_sts_t sts,
    output ngb_cmd_t      cmd
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_CLR, S_TILE_RD, S_TILE_WR, S_READ_RD,
        S_READ_WAIT, S_RECT_A, S_RECT_B, S_MUL, S_WALK_INIT, S_WALK_RD,
        S_WALK_WR, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg;

    assign s_tready = tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.clr_step = 1'b1;
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.dispatch = 1'b1;
                case (sts.req)
                    REQ_CLEAR: begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_CLR;
                    end
                    REQ_TILE:  state_next = (sts.err || sts.tile_empty) ? S_DONE : S_TILE_RD;
                    REQ_RECT:  state_next = sts.err ? S_DONE : S_RECT_A;
                    REQ_READ:  state_next = sts.err ? S_DONE : S_READ_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.sweep_last) state_next = S_DONE;
            end
            S_TILE_RD: begin
                cmd.rd_cell = 1'b1;
                state_next  = S_TILE_WR;
            end
            S_TILE_WR: begin
                cmd.tile_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_READ_RD: begin
                cmd.rd_cell = 1'b1;
                state_next  = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                cmd.read_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_RECT_A: begin
                cmd.rect_a = 1'b1;
                state_next = S_RECT_B;
            end
            S_RECT_B: begin
                cmd.rect_b = 1'b1;
                state_next = sts.rect_skip ? S_DONE : S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last) state_next = S_WALK_INIT;
            end
            S_WALK_INIT: begin
                cmd.walk_init = 1'b1;
                state_next    = sts.walk_empty ? S_DONE : S_WALK_RD;
            end
            S_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_WR;
            end
            S_WALK_WR: begin
                cmd.walk_wr = 1'b1;
                state_next  = sts.walk_last ? S_DONE : S_WALK_RD;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            tready_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tready_reg <= (state_next == S_IDLE);
        end
    end
endmodule
`default_nettype wire

### rtl/ngb_dp.sv
// Datapath of the grid builder: configuration, item and statistics registers,
// cell store, shared multiplier for rectangle bounds, walk counters.
// Depends on ngb_pkg and ngb_ram.
`timescale 1ns / 1ps
`default_nettype none
module ngb_dp import ngb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int RULE_COUNT = DEF_RULE_COUNT,
    parameter int MIN_COST   = DEF_MIN_COST,
    parameter int MAX_COST   = DEF_MAX_COST,
    parameter int SOLID_MASK = DEF_SOLID_MASK
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_wr_index,
    input  wire logic [CFG_DW-1:0] cfg_wr_data,
    input  wire logic [135:0]      s_tdata,
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [87:0]            m_tdata,
    output logic [1:0]             m_tuser,
    input  wire ngb_cmd_t          cmd,
    output ngb_sts_t               sts
);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [7:0]  MINC   = 8'(MIN_COST);
    localparam logic [15:0] SMASK  = 16'(SOLID_MASK);

    // configuration
    logic [GW-1:0]  grid_w_reg, grid_h_reg;
    logic [CSW-1:0] cell_size_reg;
    logic [ICW-1:0] inv_cell_reg;
    logic [RW-1:0]  rule_reg [RULE_SLOTS];

    // item
    logic [1:0]    req_reg;
    logic [7:0]    cx_reg, cy_reg;
    logic          empty_reg;
    logic [15:0]   mat_reg;
    logic signed [QW-1:0] rx_reg, ry_reg, rw_reg, rh_reg;

    // statistics and result
    logic [16:0] solid_reg, weighted_reg, blocked_reg;
    logic [15:0] rect_reg;
    logic [7:0]  peak_reg;
    logic [1:0]  status_reg;
    logic        ob_reg;
    logic [7:0]  oc_reg;
    logic        mvalid_reg;
    logic [87:0] mdata_reg;
    logic [1:0]  muser_reg;

    // rectangle
    logic signed [25:0] mxx_reg, mxy_reg;
    logic [24:0]        mapx_reg, mapy_reg;
    logic [24:0]        cl_reg [4];
    logic [48:0]        prod_reg;
    logic [2:0]         k_reg;
    logic [GW-1:0]      crd_reg [4];    // x0, y0, x1, y1
    logic [GW-1:0]      wx_reg, wy_reg;
    logic [AW-1:0]      sweep_reg;

    logic [GW-1:0] w_eff, h_eff;
    logic          bad_rule, cell_out, found, bad_size, rect_skip;
    logic [7:0]    rule_cost;
    logic [1:0]    status_code;
    logic [AW-1:0] item_addr, walk_addr, raddr, waddr;
    logic          we;
    logic [8:0]    wdata, rdata;
    logic signed [26:0] mnx_s, mny_s, mapx_s, mapy_s;
    logic [24:0]   p_int;
    logic [GW-1:0] dim_m1, clamped;
    logic [1:0]    kp;
    logic          solid, blk_old;

    function automatic logic [24:0] grid_w_mul(input logic [GW-1:0] d,
                                               input logic [CSW-1:0] c);
        grid_w_mul = 25'(d) * 25'(c);
    endfunction

    always_comb begin
        w_eff = grid_w_reg;
        if (grid_w_reg == '0) w_eff = GW'(1);
        else if (int'(grid_w_reg) > MAX_WIDTH) w_eff = GW'(MAX_WIDTH);
        h_eff = grid_h_reg;
        if (grid_h_reg == '0) h_eff = GW'(1);
        else if (int'(grid_h_reg) > MAX_HEIGHT) h_eff = GW'(MAX_HEIGHT);
    end

    // rule checks: any enabled rule with cost out of range, first flag match
    always_comb begin
        bad_rule  = 1'b0;
        found     = 1'b0;
        rule_cost = MINC;
        for (int i = 0; i < RULE_SLOTS; i++) begin
            if (i < RULE_COUNT && rule_reg[i][23:8] != 16'd0) begin
                if (int'(rule_reg[i][7:0]) < MIN_COST || int'(rule_reg[i][7:0]) > MAX_COST)
                    bad_rule = 1'b1;
                if (!found && rule_reg[i][23:8] == mat_reg) begin
                    found     = 1'b1;
                    rule_cost = rule_reg[i][7:0];
                end
            end
        end
    end

    assign cell_out = ({1'b0, cx_reg} >= w_eff) || ({1'b0, cy_reg} >= h_eff);
    assign bad_size = (rw_reg <= 0) || (rh_reg <= 0);

    always_comb begin
        case (req_reg)
            REQ_TILE: status_code = bad_rule ? ST_BAD_RULE : (cell_out ? ST_OUT_MAP : ST_OK);
            REQ_RECT: status_code = bad_size ? ST_BAD_RECT : ST_OK;
            REQ_READ: status_code = cell_out ? ST_OUT_MAP : ST_OK;
            default:  status_code = ST_OK;
        endcase
    end

    assign mnx_s  = 27'(rx_reg);
    assign mny_s  = 27'(ry_reg);
    assign mapx_s = $signed({2'b00, mapx_reg});
    assign mapy_s = $signed({2'b00, mapy_reg});
    assign rect_skip = (mapx_reg == '0) || (mapy_reg == '0) || (mxx_reg <= 0)
                    || (mxy_reg <= 0) || (mnx_s >= mapx_s) || (mny_s >= mapy_s);

    // clamp of the previous product to the last column or row
    assign kp      = 2'(k_reg - 3'd1);
    assign dim_m1  = kp[0] ? (h_eff - GW'(1)) : (w_eff - GW'(1));
    assign p_int   = prod_reg[48:24];
    assign clamped = (p_int > 25'(dim_m1)) ? dim_m1 : GW'(p_int);

    assign item_addr = AW'(int'(cy_reg) * MAX_WIDTH + int'(cx_reg));
    assign walk_addr = AW'(int'(wy_reg) * MAX_WIDTH + int'(wx_reg));
    assign raddr     = cmd.walk_rd ? walk_addr : item_addr;

    assign blk_old = rdata[8];
    assign solid   = (mat_reg & SMASK) != 16'd0;

    always_comb begin
        we    = 1'b0;
        waddr = item_addr;
        wdata = {1'b0, MINC};
        if (cmd.clr_step) begin
            we    = 1'b1;
            waddr = sweep_reg;
        end else if (cmd.tile_wr) begin
            we    = 1'b1;
            wdata = {blk_old | solid, rule_cost};
        end else if (cmd.walk_wr) begin
            we    = !blk_old;
            waddr = walk_addr;
            wdata = {1'b1, rdata[7:0]};
        end
    end

    ngb_ram #(.WIDTH(9), .DEPTH(CELLS)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        sts            = '0;
        sts.req        = req_reg;
        sts.err        = status_code != ST_OK;
        sts.tile_empty = empty_reg;
        sts.rect_skip  = rect_skip;
        sts.mul_last   = k_reg == 3'd4;
        sts.walk_empty = (crd_reg[0] > crd_reg[2]) || (crd_reg[1] > crd_reg[3]);
        sts.walk_last  = (wx_reg == crd_reg[2]) && (wy_reg == crd_reg[3]);
        sts.sweep_last = int'(sweep_reg) == CELLS - 1;
        sts.out_busy   = mvalid_reg && !m_tready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg    <= RST_GRID;
            grid_h_reg    <= RST_GRID;
            cell_size_reg <= RST_CS;
            inv_cell_reg  <= RST_ICS;
            for (int i = 0; i < RULE_SLOTS; i++) rule_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_GRID_WIDTH:  grid_w_reg    <= cfg_wr_data[GW-1:0];
                CFG_GRID_HEIGHT: grid_h_reg    <= cfg_wr_data[GW-1:0];
                CFG_CELL_SIZE:   cell_size_reg <= cfg_wr_data[CSW-1:0];
                CFG_INV_CELL:    inv_cell_reg  <= cfg_wr_data;
                CFG_RULE_0:      rule_reg[0]   <= cfg_wr_data;
                CFG_RULE_1:      rule_reg[1]   <= cfg_wr_data;
                CFG_RULE_2:      rule_reg[2]   <= cfg_wr_data;
                CFG_RULE_3:      rule_reg[3]   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // item, rectangle and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_tuser;
            cx_reg    <= s_tdata[7:0];
            cy_reg    <= s_tdata[15:8];
            empty_reg <= s_tdata[16];
            mat_reg   <= s_tdata[32:17];
            rx_reg    <= s_tdata[56:33];
            ry_reg    <= s_tdata[80:57];
            rw_reg    <= s_tdata[104:81];
            rh_reg    <= s_tdata[128:105];
        end
        if (cmd.dispatch) begin
            status_reg <= status_code;
            ob_reg     <= 1'b0;
            oc_reg     <= 8'd0;
        end
        if (cmd.read_cap) begin
            ob_reg <= rdata[8];
            oc_reg <= rdata[7:0];
        end
        if (cmd.rect_a) begin
            mxx_reg  <= 26'(rx_reg) + 26'(rw_reg);
            mxy_reg  <= 26'(ry_reg) + 26'(rh_reg);
            mapx_reg <= grid_w_mul(w_eff, cell_size_reg);
            mapy_reg <= grid_w_mul(h_eff, cell_size_reg);
        end
        if (cmd.rect_b) begin
            cl_reg[0] <= (rx_reg < 0) ? 25'd0 : 25'(rx_reg);
            cl_reg[1] <= (ry_reg < 0) ? 25'd0 : 25'(ry_reg);
            cl_reg[2] <= ((27'(mxx_reg) < mapx_s) ? 25'(mxx_reg) : mapx_reg) - 25'd1;
            cl_reg[3] <= ((27'(mxy_reg) < mapy_s) ? 25'(mxy_reg) : mapy_reg) - 25'd1;
        end
        if (cmd.mul_step) begin
            if (k_reg != 3'd4) prod_reg <= cl_reg[k_reg[1:0]] * inv_cell_reg;
            if (k_reg != 3'd0) crd_reg[kp] <= clamped;
        end
        if (cmd.out_load) begin
            mdata_reg <= {4'd0, blocked_reg, rect_reg, peak_reg, weighted_reg,
                          solid_reg, oc_reg, ob_reg};
            muser_reg <= status_reg;
        end
    end

    // control counters and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg    <= '0;
            k_reg        <= '0;
            wx_reg       <= '0;
            wy_reg       <= '0;
            solid_reg    <= '0;
            weighted_reg <= '0;
            blocked_reg  <= '0;
            rect_reg     <= '0;
            peak_reg     <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            if (cmd.clr_start) begin
                sweep_reg    <= '0;
                solid_reg    <= '0;
                weighted_reg <= '0;
                blocked_reg  <= '0;
                rect_reg     <= '0;
                peak_reg     <= '0;
            end
            if (cmd.clr_step) begin
                sweep_reg <= sts.sweep_last ? '0 : sweep_reg + AW'(1);
            end
            if (cmd.tile_wr) begin
                if (solid) begin
                    if (solid_reg != CNT17_MAX) solid_reg <= solid_reg + 17'd1;
                    if (!blk_old && blocked_reg != CNT17_MAX)
                        blocked_reg <= blocked_reg + 17'd1;
                end
                if (rule_cost > MINC) begin
                    if (weighted_reg != CNT17_MAX) weighted_reg <= weighted_reg + 17'd1;
                    if (rule_cost > peak_reg) peak_reg <= rule_cost;
                end
            end
            if (cmd.rect_a && rect_reg != CNT16_MAX) rect_reg <= rect_reg + 16'd1;
            if (cmd.rect_b) k_reg <= '0;
            if (cmd.mul_step) k_reg <= k_reg + 3'd1;
            if (cmd.walk_init) begin
                wx_reg <= crd_reg[0];
                wy_reg <= crd_reg[1];
            end
            if (cmd.walk_wr) begin
                if (!blk_old && blocked_reg != CNT17_MAX) blocked_reg <= blocked_reg + 17'd1;
                if (wx_reg == crd_reg[2]) begin
                    wx_reg <= crd_reg[0];
                    wy_reg <= wy_reg + GW'(1);
                end else begin
                    wx_reg <= wx_reg + GW'(1);
                end
            end
            if (cmd.out_load) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
endmodule
`default_nettype wire

### dv/nav_grid_builder_top_tb.sv
// Testbench for nav_grid_builder_top: directed table, then randomized phases
// checked against an in-bench model of the cell store and statistics.
// Depends on ngb_pkg and the RTL of nav_grid_builder_top.
`timescale 1ns / 1ps
module nav_grid_builder_top_tb;
    import ngb_pkg::*;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic        te;
        logic [15:0] mat;
        logic [23:0] rx;
        logic [23:0] ry;
        logic [23:0] rw;
        logic [23:0] rh;
    } grid_req_t;

    typedef struct packed {
        logic [1:0]  st;
        logic        ob;
        logic [7:0]  oc;
        logic [16:0] solid;
        logic [16:0] wtd;
        logic [7:0]  peak;
        logic [15:0] rects;
        logic [16:0] blkd;
    } grid_res_t;

    // directed row: typed = status/cell fields are given literally
    typedef struct packed {
        grid_req_t  rq;
        logic       typed;
        logic [1:0] st;
        logic       ob;
        logic [7:0] oc;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_wr_index = '0;
    logic [CFG_DW-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0] m_tuser;

    nav_grid_builder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // model state
    bit              blk_map [65536];
    byte unsigned    cost_map[65536];
    logic [8:0]      gw, gh;
    logic [15:0]     csz;
    logic [23:0]     icz;
    logic [23:0]     rule_reg[4];
    logic [16:0]     solid_n, wtd_n, blk_n;
    logic [7:0]      peak_n;
    logic [15:0]     rect_n;

    grid_res_t cell_results_q[$];
    int fails = 0;
    bit tx_burst = 0, rx_burst = 0;

    function automatic int unsigned eff_dim(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    task automatic wipe_grid();
        for (int i = 0; i < 65536; i++) begin
            blk_map[i] = 0;
            cost_map[i] = DEF_MIN_COST;
        end
        solid_n = 0; wtd_n = 0; blk_n = 0; peak_n = 0; rect_n = 0;
    endtask

    task automatic block_cell(input int unsigned idx);
        if (!blk_map[idx]) begin
            blk_map[idx] = 1;
            if (blk_n < CNT17_MAX) blk_n++;
        end
    endtask

    task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_GRID_WIDTH:  gw = val[8:0];
            CFG_GRID_HEIGHT: gh = val[8:0];
            CFG_CELL_SIZE:   csz = val[15:0];
            CFG_INV_CELL:    icz = val;
            CFG_RULE_0:      rule_reg[0] = val;
            CFG_RULE_1:      rule_reg[1] = val;
            CFG_RULE_2:      rule_reg[2] = val;
            default:         rule_reg[3] = val;
        endcase
    endtask

    task automatic grid_step(input grid_req_t it, output grid_res_t r);
        int unsigned w, h, idx, cost;
        longint mnx, mny, rwd, rht, mxx, mxy, mapx, mapy, x0, y0, x1, y1;
        bit bad, found;
        w = eff_dim(gw);
        h = eff_dim(gh);
        r = '0;
        case (it.req)
            REQ_CLEAR: wipe_grid();
            REQ_TILE: begin
                bad = 0;
                for (int i = 0; i < DEF_RULE_COUNT; i++)
                    if (rule_reg[i][23:8] != 0 && (rule_reg[i][7:0] < DEF_MIN_COST ||
                        rule_reg[i][7:0] > DEF_MAX_COST)) bad = 1;
                if (bad) r.st = ST_BAD_RULE;
                else if (it.cx >= w || it.cy >= h) r.st = ST_OUT_MAP;
                else if (!it.te) begin
                    idx = it.cy * 256 + it.cx;
                    if ((it.mat & DEF_SOLID_MASK) != 0) begin
                        block_cell(idx);
                        if (solid_n < CNT17_MAX) solid_n++;
                    end
                    cost = DEF_MIN_COST;
                    found = 0;
                    for (int i = 0; i < DEF_RULE_COUNT; i++)
                        if (!found && rule_reg[i][23:8] != 0 && rule_reg[i][23:8] == it.mat) begin
                            cost = rule_reg[i][7:0];
                            found = 1;
                        end
                    cost_map[idx] = cost;
                    if (cost > DEF_MIN_COST) begin
                        if (wtd_n < CNT17_MAX) wtd_n++;
                        if (cost > peak_n) peak_n = cost;
                    end
                end
            end
            REQ_RECT: begin
                mnx = $signed(it.rx); mny = $signed(it.ry);
                rwd = $signed(it.rw); rht = $signed(it.rh);
                if (rwd <= 0 || rht <= 0) r.st = ST_BAD_RECT;
                else begin
                    if (rect_n < CNT16_MAX) rect_n++;
                    mxx = mnx + rwd;
                    mxy = mny + rht;
                    mapx = longint'(w) * csz;
                    mapy = longint'(h) * csz;
                    if (mapx > 0 && mapy > 0 && mxx > 0 && mxy > 0 && mnx < mapx && mny < mapy)
                    begin
                        if (mnx < 0) mnx = 0;
                        if (mny < 0) mny = 0;
                        if (mxx > mapx) mxx = mapx;
                        if (mxy > mapy) mxy = mapy;
                        // max edge is exclusive: one LSB below it
                        x0 = (mnx * icz) >>> 24;       if (x0 > w - 1) x0 = w - 1;
                        y0 = (mny * icz) >>> 24;       if (y0 > h - 1) y0 = h - 1;
                        x1 = ((mxx - 1) * icz) >>> 24; if (x1 > w - 1) x1 = w - 1;
                        y1 = ((mxy - 1) * icz) >>> 24; if (y1 > h - 1) y1 = h - 1;
                        for (longint y = y0; y <= y1; y++)
                            for (longint x = x0; x <= x1; x++)
                                block_cell(y * 256 + x);
                    end
                end
            end
            default: begin
                if (it.cx >= w || it.cy >= h) r.st = ST_OUT_MAP;
                else begin
                    idx = it.cy * 256 + it.cx;
                    r.ob = blk_map[idx];
                    r.oc = cost_map[idx];
                end
            end
        endcase
        r.solid = solid_n; r.wtd = wtd_n; r.peak = peak_n;
        r.rects = rect_n; r.blkd = blk_n;
    endtask

    // called at a rising edge; returns at the edge that accepted the word
    task automatic send_word(input grid_req_t it);
        int gap;
        grid_res_t r;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, it.rh, it.rw, it.ry, it.rx, it.mat, it.te, it.cy, it.cx};
        s_tuser <= it.req;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        grid_step(it, r);
        cell_results_q.push_back(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (cell_results_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic load_regs(input logic [8:0] w, input logic [8:0] h, input logic [15:0] cs,
                             input logic [23:0] ic, input logic [23:0] r0,
                             input logic [23:0] r1, input logic [23:0] r2,
                             input logic [23:0] r3);
        drain();
        set_reg(CFG_GRID_WIDTH, w);
        set_reg(CFG_GRID_HEIGHT, h);
        set_reg(CFG_CELL_SIZE, cs);
        set_reg(CFG_INV_CELL, ic);
        set_reg(CFG_RULE_0, r0);
        set_reg(CFG_RULE_1, r1);
        set_reg(CFG_RULE_2, r2);
        set_reg(CFG_RULE_3, r3);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic grid_req_t rand_req(input bit wide_rect_noise);
        grid_req_t it;
        int unsigned w, h, pick;
        longint span, cs;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 99);
        w = eff_dim(gw);
        h = eff_dim(gh);
        cs = csz;
        if (pick < 12) begin
            it.req = $urandom_range(1, 3);
            if (it.req == REQ_RECT && !wide_rect_noise) it.req = REQ_READ;
        end else if (pick < 77) begin
            it.req = pick < 52 ? REQ_TILE : REQ_READ;
            it.cx = $urandom_range(0, w < 255 ? w : 255);
            it.cy = $urandom_range(0, h < 255 ? h : 255);
            it.te = $urandom_range(0, 9) == 0;
            case ($urandom_range(0, 4))
                0: it.mat = rule_reg[$urandom_range(0, 3)][23:8];
                1: it.mat = 16'd1;
                2: it.mat = 16'hFFFF;
                default: ;
            endcase
        end else begin
            it.req = REQ_RECT;
            span = longint'(w) * cs;
            if (span > 8000000) span = 8000000;
            it.rx = longint'($urandom_range(0, span + 2 * cs)) - cs;
            span = longint'(h) * cs;
            if (span > 8000000) span = 8000000;
            it.ry = longint'($urandom_range(0, span + 2 * cs)) - cs;
            it.rw = $urandom_range(1, 3 * cs);
            it.rh = $urandom_range(1, 3 * cs);
            if ($urandom_range(0, 12) == 0) it.rw = -longint'($urandom_range(0, cs));
            if ($urandom_range(0, 12) == 0) it.rh = -longint'($urandom_range(0, cs));
        end
        return it;
    endfunction

    task automatic run_random(input int n, input bit wide_rect_noise, input int pause_at);
        grid_req_t it;
        for (int i = 0; i < n; i++) begin
            if (i % 80 == 0) begin
                tx_burst = $urandom_range(0, 3) == 0;
                rx_burst = $urandom_range(0, 3) == 0;
            end
            if (i == pause_at) drain();
            it = rand_req(wide_rect_noise);
            if ($urandom_range(0, 399) == 0) it.req = REQ_CLEAR;
            send_word(it);
        end
    endtask

    function automatic dir_row_t row(input logic [1:0] req, input logic [7:0] cx,
                                     input logic [7:0] cy, input logic te,
                                     input logic [15:0] mat, input logic [23:0] rx,
                                     input logic [23:0] ry, input logic [23:0] rw,
                                     input logic [23:0] rh, input logic typed,
                                     input logic [1:0] st, input logic ob,
                                     input logic [7:0] oc);
        return '{'{req, cx, cy, te, mat, rx, ry, rw, rh}, typed, st, ob, oc};
    endfunction

    // result side
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            int gap;
            gap = rx_burst ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
        end
    end

    grid_res_t want, got;
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[0], m_tdata[8:1], m_tdata[25:9], m_tdata[42:26],
                   m_tdata[50:43], m_tdata[66:51], m_tdata[83:67]};
            if (cell_results_q.size() == 0) begin
                $error("result word with nothing expected");
                fails++;
            end else begin
                want = cell_results_q.pop_front();
                if (got.st != want.st) begin
                    $error("status exp %0d got %0d", want.st, got.st); fails++;
                end
                if (got.ob != want.ob) begin
                    $error("out_blocked exp %0d got %0d", want.ob, got.ob); fails++;
                end
                if (got.oc != want.oc) begin
                    $error("out_cost exp %0d got %0d", want.oc, got.oc); fails++;
                end
                if (got.solid != want.solid) begin
                    $error("solid_count exp %0d got %0d", want.solid, got.solid); fails++;
                end
                if (got.wtd != want.wtd) begin
                    $error("weighted_count exp %0d got %0d", want.wtd, got.wtd); fails++;
                end
                if (got.peak != want.peak) begin
                    $error("peak_cost exp %0d got %0d", want.peak, got.peak); fails++;
                end
                if (got.rects != want.rects) begin
                    $error("rect_count exp %0d got %0d", want.rects, got.rects); fails++;
                end
                if (got.blkd != want.blkd) begin
                    $error("blocked_count exp %0d got %0d", want.blkd, got.blkd); fails++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("[nav_grid_builder_top] ERROR");
        $finish;
    end

    initial begin
        dir_row_t dir_tab[$];
        grid_req_t big;
        gw = RST_GRID; gh = RST_GRID; csz = RST_CS; icz = RST_ICS;
        for (int i = 0; i < 4; i++) rule_reg[i] = '0;
        wipe_grid();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        dir_tab.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 1));
        dir_tab.push_back(row(REQ_READ, 255, 255, 1, 16'hFFFF, '1, '1, '1, '1, 1, ST_OK, 0, 1));
        dir_tab.push_back(row(REQ_TILE, 10, 10, 1, 16'hFFFF, 0, 0, 0, 0, 1, ST_OK, 0, 0));
        dir_tab.push_back(row(REQ_TILE, 3, 4, 0, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_TILE, 255, 255, 0, 16'hFFFF, '1, '1, '1, '1, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_TILE, 0, 0, 0, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_READ, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // one-LSB rectangle, then the last cell exactly
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 65280, 65280, 256, 256, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 0, 0, 0, 256, 1, ST_BAD_RECT, 0, 0));
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 0, 0, 256, 24'h800000, 1, ST_BAD_RECT,
                              0, 0));
        // ends one LSB short of the origin: nothing marked
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 24'h800000, 24'h800000, 24'h7FFFFF,
                              24'h7FFFFF, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 24'h7FFFFF, 0, 1, 1, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, -512, -512, 1024, 768, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_RECT, 0, 0, 0, 0, 256, 512, 256, 256, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_READ, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_READ, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0));
        dir_tab.push_back(row(REQ_READ, 255, 255, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 1));

        @(posedge aclk);
        foreach (dir_tab[i]) begin
            send_word(dir_tab[i].rq);
            if (dir_tab[i].typed) begin
                cell_results_q[cell_results_q.size() - 1].st = dir_tab[i].st;
                cell_results_q[cell_results_q.size() - 1].ob = dir_tab[i].ob;
                cell_results_q[cell_results_q.size() - 1].oc = dir_tab[i].oc;
            end
        end

        // small map, mixed rules including a disabled one and the all-ones rule
        load_regs(16, 16, 256, 65536, {16'h0002, 8'h40}, {16'h0003, 8'hFF},
                  24'h000000, 24'hFFFFFF);
        run_random(350, 1, -1);
        // width below range, height above, finest cell
        load_regs(0, 9'h1FF, 1, 24'hFFFFFF, {16'h0001, 8'd1}, {16'hFFFF, 8'h02},
                  {16'h8000, 8'h90}, {16'h0000, 8'hFF});
        run_random(250, 1, -1);
        // enabled rule with cost below minimum; reciprocal inconsistent
        load_regs(8, 8, 16'hFFFF, 1, {16'h0004, 8'h20}, {16'h0005, 8'h00},
                  24'h000000, {16'h0006, 8'h30});
        run_random(200, 1, -1);
        load_regs(256, 256, 256, 65536, {16'h1234, 8'h11}, {16'h0001, 8'h55},
                  {16'h00F0, 8'hC0}, {16'h0003, 8'h02});
        big = '{REQ_RECT, 0, 0, 0, 0, -256, -256, 24'h7FFFFF, 24'h7FFFFF};
        send_word(big);
        run_random(450, 0, 200);
        load_regs(255, 1, 16'h8000, 24'h000200, {16'h0010, 8'hFE}, {16'h0020, 8'h01},
                  {16'h0040, 8'h7F}, {16'hFFFE, 8'h03});
        run_random(300, 1, -1);

        drain();
        repeat (30) @(posedge aclk);
        if (fails == 0) $display("[nav_grid_builder_top] OK");
        else $display("[nav_grid_builder_top] ERROR");
        $finish;
    end
endmodule

### nav_grid_builder_top.f
rtl/ngb_pkg.sv
rtl/ngb_ram.sv
rtl/ngb_ctrl.sv
rtl/ngb_dp.sv
rtl/nav_grid_builder_top.sv
dv/nav_grid_builder_top_tb.sv
